>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define SISU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check with no reset mask.
`define SISU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sisu_pkg.sv
`default_nettype none

package sisu_pkg;

  localparam int MAX_CAPACITY = 256;
  localparam int ROW_BITS     = 16;
  localparam int ADDR_BITS    = $clog2(MAX_CAPACITY);
  localparam int SIZE_BITS    = ADDR_BITS + 1;

  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_BITS-1:0] cnt_t;
  typedef logic [SIZE_BITS:0]   ext_t;

  localparam cnt_t CAP_MAX  = cnt_t'(MAX_CAPACITY);
  localparam ext_t FILL_MAX = ext_t'(MAX_CAPACITY);

  // request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_BEGIN  = 3'd2;
  localparam logic [2:0] REQ_ELEM   = 3'd3;
  localparam logic [2:0] REQ_END    = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // merge outcomes
  localparam logic [1:0] ST_UNCHANGED = 2'd0;
  localparam logic [1:0] ST_CHANGED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_M_FETCH,
    S_M_TEST,
    S_M_INSERT,
    S_E_FETCH,
    S_E_COPY,
    S_C_RD,
    S_C_WR,
    S_END_DONE,
    S_READ_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input side may transfer
    logic clear;
    logic append;
    logic begin_m;
    logic rd_scan;    // read stored entry at scan pointer
    logic rd_idx;     // read stored entry at requested index
    logic copy;       // stored head -> merge buffer, advance scan
    logic set_ovf;
    logic insert;     // new element into buffer and result register
    logic commit;     // size <- fill, scan pointer rewinds for copy-back
    logic rd_buf;
    logic cp_back;    // buffer entry -> stored set
    logic end_emit;
    logic read_emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       in_fire;
    logic [2:0] req;
    logic       elem_skip;
    logic       end_quick;
    logic       scan_left;
    logic       buf_full;
    logic       head_lt;
    logic       head_eq;
    logic       insert_ok;
    logic       out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> src/sisu_req_if.sv
`default_nettype none

interface sisu_req_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   req_type;
  logic [sisu_pkg::ROW_BITS-1:0]  value;
  logic [sisu_pkg::ROW_BITS-1:0]  threshold;
  logic [sisu_pkg::SIZE_BITS-1:0] capacity;
  logic [sisu_pkg::ADDR_BITS-1:0] index;

  modport source (output valid, req_type, value, threshold, capacity, index, input ready);
  modport sink   (input valid, req_type, value, threshold, capacity, index, output ready);
endinterface

`default_nettype wire

>>> src/sisu_rsp_if.sv
`default_nettype none

interface sisu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [sisu_pkg::ROW_BITS-1:0]  value_out;
  logic [sisu_pkg::ADDR_BITS-1:0] position;
  logic [1:0]                   status;
  logic [sisu_pkg::SIZE_BITS-1:0] set_size;

  modport source (output valid, kind, value_out, position, status, set_size, input ready);
  modport sink   (input valid, kind, value_out, position, status, set_size, output ready);
endinterface

`default_nettype wire

>>> src/sisu_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module sisu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  sisu_pkg::stat_t stat,
  output sisu_pkg::cmd_t  cmd
);

  sisu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sisu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sisu_pkg::S_IDLE: begin
        if (stat.in_fire) state_next = sisu_pkg::S_DISPATCH;
      end
      sisu_pkg::S_DISPATCH: begin
        case (stat.req)
          sisu_pkg::REQ_ELEM: begin
            state_next = stat.elem_skip ? sisu_pkg::S_IDLE : sisu_pkg::S_M_FETCH;
          end
          sisu_pkg::REQ_END: begin
            state_next = stat.end_quick ? sisu_pkg::S_END_DONE : sisu_pkg::S_E_FETCH;
          end
          sisu_pkg::REQ_READ: state_next = sisu_pkg::S_READ_WAIT;
          default:            state_next = sisu_pkg::S_IDLE;
        endcase
      end
      sisu_pkg::S_M_FETCH: begin
        state_next = stat.scan_left ? sisu_pkg::S_M_TEST : sisu_pkg::S_M_INSERT;
      end
      sisu_pkg::S_M_TEST: begin
        if (stat.head_lt) begin
          state_next = stat.buf_full ? sisu_pkg::S_IDLE : sisu_pkg::S_M_FETCH;
        end else if (stat.head_eq) begin
          state_next = sisu_pkg::S_IDLE;
        end else begin
          state_next = sisu_pkg::S_M_INSERT;
        end
      end
      sisu_pkg::S_M_INSERT: begin
        if (!stat.insert_ok || !stat.out_busy) state_next = sisu_pkg::S_IDLE;
      end
      sisu_pkg::S_E_FETCH: begin
        if (stat.scan_left && !stat.buf_full) begin
          state_next = sisu_pkg::S_E_COPY;
        end else begin
          state_next = sisu_pkg::S_C_RD;
        end
      end
      sisu_pkg::S_E_COPY: state_next = sisu_pkg::S_E_FETCH;
      sisu_pkg::S_C_RD: begin
        state_next = stat.scan_left ? sisu_pkg::S_C_WR : sisu_pkg::S_END_DONE;
      end
      sisu_pkg::S_C_WR: state_next = sisu_pkg::S_C_RD;
      sisu_pkg::S_END_DONE: begin
        if (!stat.out_busy) state_next = sisu_pkg::S_IDLE;
      end
      sisu_pkg::S_READ_WAIT: begin
        if (!stat.out_busy) state_next = sisu_pkg::S_IDLE;
      end
      default: state_next = sisu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      sisu_pkg::S_IDLE: cmd.take = 1'b1;
      sisu_pkg::S_DISPATCH: begin
        case (stat.req)
          sisu_pkg::REQ_CLEAR:  cmd.clear   = 1'b1;
          sisu_pkg::REQ_APPEND: cmd.append  = 1'b1;
          sisu_pkg::REQ_BEGIN:  cmd.begin_m = 1'b1;
          sisu_pkg::REQ_READ:   cmd.rd_idx  = 1'b1;
          default: ;
        endcase
      end
      sisu_pkg::S_M_FETCH: cmd.rd_scan = stat.scan_left;
      sisu_pkg::S_M_TEST: begin
        // equal head is copied and the offered index dropped
        if (stat.head_lt || stat.head_eq) cmd.copy = !stat.buf_full;
      end
      sisu_pkg::S_M_INSERT: begin
        if (!stat.insert_ok) begin
          cmd.set_ovf = 1'b1;
        end else begin
          cmd.insert = !stat.out_busy;
        end
      end
      sisu_pkg::S_E_FETCH: begin
        if (stat.scan_left && !stat.buf_full) begin
          cmd.rd_scan = 1'b1;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      sisu_pkg::S_E_COPY:    cmd.copy      = 1'b1;
      sisu_pkg::S_C_RD:      cmd.rd_buf    = stat.scan_left;
      sisu_pkg::S_C_WR:      cmd.cp_back   = 1'b1;
      sisu_pkg::S_END_DONE:  cmd.end_emit  = !stat.out_busy;
      sisu_pkg::S_READ_WAIT: cmd.read_emit = !stat.out_busy;
      default: ;
    endcase
  end

  `SISU_ASSERT(a_fire_dispatch, clk, rst, stat.in_fire |=> state == sisu_pkg::S_DISPATCH, "accepted item not dispatched")

endmodule

`default_nettype wire

>>> src/sisu_dp.sv
`default_nettype none
`include "assert_macros.svh"

module sisu_dp (
  input  logic            clk,
  input  logic            rst,
  sisu_req_if.sink        req,
  sisu_rsp_if.source      rsp,
  input  sisu_pkg::cmd_t  cmd,
  output sisu_pkg::stat_t stat
);

  // latched request
  logic [2:0]      req_code;
  sisu_pkg::row_t  val_r;
  sisu_pkg::row_t  thr_in;
  sisu_pkg::cnt_t  cap_in;
  sisu_pkg::addr_t idx_r;

  // set and merge state
  sisu_pkg::cnt_t stored_size;
  sisu_pkg::cnt_t set_capacity;
  sisu_pkg::cnt_t scan_pointer;
  sisu_pkg::cnt_t new_count;
  sisu_pkg::row_t merge_threshold;
  logic           overflow_flag;
  sisu_pkg::row_t stored_last;
  sisu_pkg::row_t last_merged;

  // memories
  sisu_pkg::row_t stored_mem [sisu_pkg::MAX_CAPACITY];
  sisu_pkg::row_t buf_mem    [sisu_pkg::MAX_CAPACITY];
  sisu_pkg::row_t stored_rd;
  sisu_pkg::row_t buf_rd;

  // result register
  logic            out_valid;
  logic [1:0]      out_kind;
  sisu_pkg::row_t  out_value;
  sisu_pkg::addr_t out_pos;
  logic [1:0]      out_status;
  sisu_pkg::cnt_t  out_size;

  logic            fire;
  sisu_pkg::ext_t  fill;
  logic            app_ok;
  logic            out_load;
  logic [1:0]      end_st;
  logic            st_we, st_re, bf_we;
  sisu_pkg::addr_t st_waddr, st_raddr;
  sisu_pkg::row_t  st_wdata, bf_wdata;
  sisu_pkg::cnt_t  cap_sat;

  assign req.ready = cmd.take;
  assign fire      = req.valid && req.ready;

  assign fill    = sisu_pkg::ext_t'(scan_pointer) + sisu_pkg::ext_t'(new_count);
  assign app_ok  = (stored_size < set_capacity) &&
                   ((stored_size == '0) || (val_r > stored_last));
  assign cap_sat = (cap_in > sisu_pkg::CAP_MAX) ? sisu_pkg::CAP_MAX : cap_in;
  assign end_st  = overflow_flag      ? sisu_pkg::ST_OVERFLOW :
                   (new_count == '0) ? sisu_pkg::ST_UNCHANGED : sisu_pkg::ST_CHANGED;
  assign out_load = cmd.insert || cmd.end_emit || cmd.read_emit;

  always_comb begin
    stat           = '0;
    stat.in_fire   = fire;
    stat.req       = req_code;
    stat.elem_skip = overflow_flag || (val_r <= merge_threshold) ||
                     ((fill != '0) && (val_r <= last_merged));
    stat.end_quick = overflow_flag || (new_count == '0);
    stat.scan_left = scan_pointer < stored_size;
    stat.buf_full  = fill >= sisu_pkg::FILL_MAX;
    stat.head_lt   = stored_rd < val_r;
    stat.head_eq   = stored_rd == val_r;
    stat.insert_ok = (sisu_pkg::ext_t'(stored_size) + sisu_pkg::ext_t'(new_count) +
                      sisu_pkg::ext_t'(1) <= sisu_pkg::ext_t'(set_capacity)) &&
                     (fill < sisu_pkg::FILL_MAX);
    stat.out_busy  = out_valid && !rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      req_code <= req.req_type;
      val_r    <= req.value;
      thr_in   <= req.threshold;
      cap_in   <= req.capacity;
      idx_r    <= req.index;
    end
  end

  // stored set port
  assign st_we    = (cmd.append && app_ok) || cmd.cp_back;
  assign st_waddr = cmd.cp_back ? scan_pointer[sisu_pkg::ADDR_BITS-1:0]
                                : stored_size[sisu_pkg::ADDR_BITS-1:0];
  assign st_wdata = cmd.cp_back ? buf_rd : val_r;
  assign st_re    = cmd.rd_scan || cmd.rd_idx;
  assign st_raddr = cmd.rd_idx ? idx_r : scan_pointer[sisu_pkg::ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (st_we) stored_mem[st_waddr] <= st_wdata;
    if (st_re) stored_rd <= stored_mem[st_raddr];
  end

  // merge buffer port
  assign bf_we    = cmd.copy || cmd.insert;
  assign bf_wdata = cmd.insert ? val_r : stored_rd;

  always_ff @(posedge clk) begin
    if (bf_we)      buf_mem[fill[sisu_pkg::ADDR_BITS-1:0]] <= bf_wdata;
    if (cmd.rd_buf) buf_rd <= buf_mem[scan_pointer[sisu_pkg::ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_size     <= '0;
      set_capacity    <= '0;
      scan_pointer    <= '0;
      new_count       <= '0;
      merge_threshold <= '0;
      overflow_flag   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        stored_size   <= '0;
        set_capacity  <= cap_sat;
        scan_pointer  <= '0;
        new_count     <= '0;
        overflow_flag <= 1'b0;
      end
      if (cmd.append && app_ok) stored_size <= stored_size + sisu_pkg::cnt_t'(1);
      if (cmd.begin_m) begin
        merge_threshold <= thr_in;
        scan_pointer    <= '0;
        new_count       <= '0;
        overflow_flag   <= 1'b0;
      end
      if (cmd.copy || cmd.cp_back) scan_pointer <= scan_pointer + sisu_pkg::cnt_t'(1);
      if (cmd.set_ovf) overflow_flag <= 1'b1;
      if (cmd.insert)  new_count <= new_count + sisu_pkg::cnt_t'(1);
      if (cmd.commit) begin
        stored_size  <= fill[sisu_pkg::SIZE_BITS-1:0];
        scan_pointer <= '0;
      end
      if (cmd.end_emit) begin
        scan_pointer  <= '0;
        new_count     <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // last entries, read only when their set is non-empty
  always_ff @(posedge clk) begin
    if (cmd.append && app_ok) stored_last <= val_r;
    if (cmd.cp_back)          stored_last <= buf_rd;
    if (cmd.copy)             last_merged <= stored_rd;
    if (cmd.insert)           last_merged <= val_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      out_kind   <= sisu_pkg::KIND_NEW;
      out_value  <= val_r;
      out_pos    <= fill[sisu_pkg::ADDR_BITS-1:0];
      out_status <= sisu_pkg::ST_UNCHANGED;
      out_size   <= '0;
    end else if (cmd.end_emit) begin
      out_kind   <= sisu_pkg::KIND_STATUS;
      out_value  <= '0;
      out_pos    <= '0;
      out_status <= end_st;
      out_size   <= stored_size;
    end else if (cmd.read_emit) begin
      out_kind   <= sisu_pkg::KIND_READ;
      out_value  <= (sisu_pkg::cnt_t'(idx_r) < stored_size) ? stored_rd : '0;
      out_pos    <= '0;
      out_status <= sisu_pkg::ST_UNCHANGED;
      out_size   <= stored_size;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_kind;
  assign rsp.value_out = out_value;
  assign rsp.position  = out_pos;
  assign rsp.status    = out_status;
  assign rsp.set_size  = out_size;

  `SISU_ASSERT(a_size_cap, clk, rst, stored_size <= sisu_pkg::CAP_MAX, "set size above maximum")
  `SISU_ASSERT(a_no_drop, clk, rst, out_load |-> !(out_valid && !rsp.ready), "result overwritten")
  `SISU_ASSERT(a_ins_ovf, clk, rst, cmd.insert |-> !overflow_flag, "insert after overflow")

endmodule

`default_nettype wire

>>> src/sorted_index_set_union.sv
`default_nettype none
// Channel  Dir  Fields
// req      in   req_type, value, threshold, capacity, index
// rsp      out  kind, value_out, position, status, set_size
//
// One request at a time. Clear, append and begin merge finish in dispatch; a read
// fetches its entry there, then emits. A skipped merge element ends in dispatch;
// else each stored entry below it (an equal one too) is fetched, tested and copied to
// the buffer, then the element is inserted or overflow flagged (dropped if equal).
// End merge emits status directly if unchanged or overflowed; else it buffers the rest
// of the set, then copies each merged entry back (one memory read, then its write).
// Synchronous reset clears all control state; set memories need no clearing pass.
// A stalled result sits in the output register; the next request is taken meanwhile.

module sorted_index_set_union (
  input logic        clk,
  input logic        rst,
  sisu_req_if.sink   req,
  sisu_rsp_if.source rsp
);

  // Command and status between sequencer and datapath.
  sisu_pkg::cmd_t  cmd;
  sisu_pkg::stat_t stat;

  // Sequencer: decodes the request, walks the merge scan and the
  // buffer copy-back one memory access at a time.
  sisu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: stored set and merge buffer memories, set counters,
  // comparators and the result register.
  sisu_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // Codes 6 and 7 have no meaning to the block; it must drop them silently.
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // Watchdog. The longest request is an end merge on a full set plus a long receiver
  // stall; the limit sits several times above ~960 requests at that bound.
  localparam int LIMIT_CYCLES = 6000000;
  // Longest request without a result: a merge element scanning 256 entries;
  // end merge on a full set takes longer. Wait past both.
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    logic [2:0]      req_type;
    sisu_pkg::row_t  value;
    sisu_pkg::row_t  threshold;
    sisu_pkg::cnt_t  capacity;
    sisu_pkg::addr_t index;
  } set_request_t;

  typedef struct packed {
    logic [1:0]      kind;
    sisu_pkg::row_t  value_out;
    sisu_pkg::addr_t position;
    logic [1:0]      status;
    sisu_pkg::cnt_t  set_size;
  } set_result_t;

  // Mirror of the stored set and the merge in progress, plus the queue of
  // results the block still owes us.
  class union_scoreboard;
    sisu_pkg::row_t stored_rows[sisu_pkg::MAX_CAPACITY];
    sisu_pkg::row_t merged_rows[sisu_pkg::MAX_CAPACITY];
    int             stored_count;
    int             cap_limit;
    int             scan_at;
    int             added;
    sisu_pkg::row_t thr_level;
    bit             overflowed;
    set_result_t    owed[$];
    int             mismatches;

    function new();
      stored_count = 0;
      cap_limit    = 0;
      thr_level    = '0;
      mismatches   = 0;
      restart_merge();
    endfunction

    function void restart_merge();
      scan_at    = 0;
      added      = 0;
      overflowed = 1'b0;
    endfunction

    // Move the next stored entry into the merged prefix; 0 when none is left or out of room.
    function bit copy_stored();
      if (scan_at >= stored_count || scan_at + added >= sisu_pkg::MAX_CAPACITY) return 1'b0;
      merged_rows[scan_at + added] = stored_rows[scan_at];
      scan_at++;
      return 1'b1;
    endfunction

    // Called on every accepted request transfer.
    function void note_request(set_request_t r);
      set_result_t res;
      int          fill;
      res = '0;
      case (r.req_type)
        sisu_pkg::REQ_CLEAR: begin
          stored_count = 0;
          cap_limit    = (r.capacity > sisu_pkg::CAP_MAX) ? sisu_pkg::MAX_CAPACITY
                                                         : int'(r.capacity);
          restart_merge();
        end
        sisu_pkg::REQ_APPEND: begin
          if (stored_count < cap_limit && stored_count < sisu_pkg::MAX_CAPACITY &&
              (stored_count == 0 || r.value > stored_rows[stored_count - 1])) begin
            stored_rows[stored_count] = r.value;
            stored_count++;
          end
        end
        sisu_pkg::REQ_BEGIN: begin
          thr_level = r.threshold;
          restart_merge();
        end
        sisu_pkg::REQ_ELEM: begin
          if (overflowed || r.value <= thr_level) return;
          fill = scan_at + added;
          if (fill > 0 && r.value <= merged_rows[fill - 1]) return;
          while (scan_at < stored_count && stored_rows[scan_at] < r.value)
            if (!copy_stored()) return;
          // already present: keep the stored copy, drop the offer
          if (scan_at < stored_count && stored_rows[scan_at] == r.value) begin
            void'(copy_stored());
            return;
          end
          if (stored_count + added + 1 > cap_limit ||
              scan_at + added >= sisu_pkg::MAX_CAPACITY) begin
            overflowed = 1'b1;
            return;
          end
          merged_rows[scan_at + added] = r.value;
          res.kind      = sisu_pkg::KIND_NEW;
          res.value_out = r.value;
          res.position  = sisu_pkg::addr_t'(scan_at + added);
          added++;
          owed.push_back(res);
        end
        sisu_pkg::REQ_END: begin
          if (overflowed) begin
            res.status = sisu_pkg::ST_OVERFLOW;
          end else if (added == 0) begin
            res.status = sisu_pkg::ST_UNCHANGED;
          end else begin
            while (scan_at < stored_count)
              if (!copy_stored()) break;
            stored_count = (scan_at + added > sisu_pkg::MAX_CAPACITY) ? sisu_pkg::MAX_CAPACITY
                                                                      : scan_at + added;
            for (int k = 0; k < stored_count; k++) stored_rows[k] = merged_rows[k];
            res.status = sisu_pkg::ST_CHANGED;
          end
          restart_merge();
          res.kind     = sisu_pkg::KIND_STATUS;
          res.set_size = sisu_pkg::cnt_t'(stored_count);
          owed.push_back(res);
        end
        sisu_pkg::REQ_READ: begin
          res.kind      = sisu_pkg::KIND_READ;
          res.value_out = (int'(r.index) < stored_count) ? stored_rows[r.index] : '0;
          res.set_size  = sisu_pkg::cnt_t'(stored_count);
          owed.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(set_result_t got);
      set_result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: kind %0d value %0d",
                                  got.kind, got.value_out));
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value_out !== want.value_out)
        report_mismatch($sformatf("kind %0d value_out %0d, want %0d",
                                  want.kind, got.value_out, want.value_out));
      if (got.position !== want.position)
        report_mismatch($sformatf("kind %0d position %0d, want %0d",
                                  want.kind, got.position, want.position));
      if (got.status !== want.status)
        report_mismatch($sformatf("kind %0d status %0d, want %0d",
                                  want.kind, got.status, want.status));
      if (got.set_size !== want.set_size)
        report_mismatch($sformatf("kind %0d set_size %0d, want %0d",
                                  want.kind, got.set_size, want.set_size));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sisu_req_if req_ch ();
  sisu_rsp_if rsp_ch ();

  sorted_index_set_union uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  union_scoreboard sb = new();

  int src_idle_pct  = 0;   // chance per cycle the sender holds valid low
  int sink_idle_pct = 0;   // chance per cycle the receiver holds ready low
  int sink_hold     = 0;   // forced receiver stall, counted down below
  int fed_items     = 0;   // meaningful request transfers so far
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready changes on the falling edge only. A pending hold-off
  // wins over the random idling.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        rsp_ch.ready = 1'b0;
        sink_hold--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Result monitor: every result transfer is checked against the oldest owed one.
  always @(posedge clk) begin : watch_results
    set_result_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.kind      = rsp_ch.kind;
      got.value_out = rsp_ch.value_out;
      got.position  = rsp_ch.position;
      got.status    = rsp_ch.status;
      got.set_size  = rsp_ch.set_size;
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one request and hold it until the transfer. Entered and left on a
  // falling edge. A negative value or aux means "random"; aux goes to the
  // field the code uses (capacity, threshold or index). Unused fields get
  // random content so every bit toggles.
  task automatic offer(logic [2:0] code, int value, int aux);
    set_request_t r;
    r.req_type  = code;
    r.value     = (value < 0) ? sisu_pkg::row_t'($urandom) : sisu_pkg::row_t'(value);
    r.threshold = (code == sisu_pkg::REQ_BEGIN && aux >= 0) ? sisu_pkg::row_t'(aux)
                                                            : sisu_pkg::row_t'($urandom);
    r.capacity  = (code == sisu_pkg::REQ_CLEAR && aux >= 0) ? sisu_pkg::cnt_t'(aux)
                                                            : sisu_pkg::cnt_t'($urandom);
    r.index     = (code == sisu_pkg::REQ_READ && aux >= 0) ? sisu_pkg::addr_t'(aux)
                                                           : sisu_pkg::addr_t'($urandom);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.req_type  = r.req_type;
    req_ch.value     = r.value;
    req_ch.threshold = r.threshold;
    req_ch.capacity  = r.capacity;
    req_ch.index     = r.index;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(r);
    if (r.req_type <= sisu_pkg::REQ_READ) fed_items++;
    @(negedge clk);
  endtask

  // n row indices, ascending, duplicates allowed, drawn from [lo, hi]. With mix set,
  // about a third come from the current stored set instead, so merges hit
  // entries that are already present.
  task automatic draw_sorted(int n, int lo, int hi, bit mix, ref int vals[$]);
    int k;
    vals.delete();
    for (k = 0; k < n; k++)
      if (mix && sb.stored_count > 0 && $urandom_range(2) == 0)
        vals.push_back(int'(sb.stored_rows[$urandom_range(0, sb.stored_count - 1)]));
      else
        vals.push_back($urandom_range(lo, hi));
    vals.sort();
  endtask

  // One random session: usually a clear, a sorted fill, then a few merges of
  // sorted streams with reads in between. Noise: out-of-order appends and
  // elements, merges without begin or end, spare codes.
  task automatic random_session();
    int cap, apps, merges, lo, hi, span, thr, m, idx;
    int vals[$];
    // window of row indices; narrow windows make overlaps with the set likely
    if ($urandom_range(3) == 0) begin
      lo = 0;
      hi = 65535;
    end else begin
      span = 1 << $urandom_range(3, 12);
      lo   = $urandom_range(0, 65535 - span);
      hi   = lo + span;
    end
    if ($urandom_range(4) != 0) begin
      // mostly small capacities so overflow is common
      case ($urandom_range(9))
        0:       cap = $urandom_range(257, 511);
        1, 2:    cap = $urandom_range(17, 48);
        default: cap = $urandom_range(0, 16);
      endcase
      offer(sisu_pkg::REQ_CLEAR, -1, cap);
      apps = $urandom_range(0, (cap > 24) ? 24 : cap + 1);
    end else begin
      apps = $urandom_range(0, 3);  // keep growing the current set
    end
    draw_sorted(apps, lo, hi, 1'b0, vals);
    foreach (vals[k]) begin
      if ($urandom_range(19) == 0) offer(sisu_pkg::REQ_APPEND, $urandom_range(0, vals[k]), -1);
      offer(sisu_pkg::REQ_APPEND, vals[k], -1);
    end
    merges = $urandom_range(1, 4);
    for (m = 0; m < merges; m++) begin
      case ($urandom_range(5))
        0:       thr = 0;
        1:       thr = (lo > 0) ? lo - 1 : 0;
        2, 3:    thr = $urandom_range(lo, hi);
        4:       thr = $urandom_range(0, 65535);
        default: thr = ($urandom_range(3) == 0) ? 65535 : lo;
      endcase
      if ($urandom_range(9) != 0) offer(sisu_pkg::REQ_BEGIN, -1, thr);
      draw_sorted($urandom_range(0, 12), lo, hi, 1'b1, vals);
      foreach (vals[k]) begin
        if ($urandom_range(15) == 0) offer(sisu_pkg::REQ_ELEM, $urandom_range(lo, hi), -1);
        offer(sisu_pkg::REQ_ELEM, vals[k], -1);
      end
      if ($urandom_range(19) != 0) offer(sisu_pkg::REQ_END, -1, -1);
      if ($urandom_range(1) == 0) begin
        idx = ($urandom_range(4) == 0) ? $urandom_range(0, 255)
            : $urandom_range(0, (sb.stored_count > 255) ? 255 : sb.stored_count);
        offer(sisu_pkg::REQ_READ, -1, idx);
      end
      if ($urandom_range(19) == 0)
        offer(($urandom_range(1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7, -1, -1);
    end
  endtask

  initial begin
    int goal, i;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = sisu_pkg::REQ_CLEAR;
    req_ch.value     = '0;
    req_ch.threshold = '0;
    req_ch.capacity  = '0;
    req_ch.index     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed ----
    offer(sisu_pkg::REQ_READ, -1, 255);          // empty set: reads 0, size 0
    offer(sisu_pkg::REQ_ELEM, 5, -1);            // no begin, capacity 0: empty-set overflow
    offer(sisu_pkg::REQ_END, -1, -1);            // -> overflow, size stays 0
    offer(sisu_pkg::REQ_CLEAR, -1, 511);         // capacity saturates to 256
    offer(sisu_pkg::REQ_APPEND, 0, -1);
    offer(sisu_pkg::REQ_APPEND, 0, -1);          // repeat: dropped
    offer(sisu_pkg::REQ_APPEND, 65535, -1);
    offer(sisu_pkg::REQ_APPEND, 100, -1);        // below last: dropped
    offer(sisu_pkg::REQ_READ, -1, 1);            // 65535
    offer(sisu_pkg::REQ_READ, -1, 2);            // past the end: 0
    offer(sisu_pkg::REQ_BEGIN, -1, 0);
    offer(sisu_pkg::REQ_ELEM, 0, -1);            // at threshold: skipped
    offer(sisu_pkg::REQ_ELEM, 7, -1);            // new at position 1
    offer(sisu_pkg::REQ_ELEM, 7, -1);            // repeated in stream: ignored
    offer(sisu_pkg::REQ_ELEM, 65535, -1);        // already stored: dropped
    offer(sisu_pkg::REQ_END, -1, -1);            // changed, size 3
    offer(REQ_SPARE_6, -1, -1);
    offer(REQ_SPARE_7, -1, -1);
    offer(sisu_pkg::REQ_CLEAR, -1, 2);
    offer(sisu_pkg::REQ_APPEND, 10, -1);
    offer(sisu_pkg::REQ_APPEND, 20, -1);
    offer(sisu_pkg::REQ_APPEND, 30, -1);         // set full: dropped
    offer(sisu_pkg::REQ_ELEM, 15, -1);           // continues without begin: overflow
    offer(sisu_pkg::REQ_END, -1, -1);            // overflow, set untouched
    offer(sisu_pkg::REQ_READ, -1, 0);            // still 10

    // ---- random, sender mostly busy, receiver mostly idle ----
    src_idle_pct  = 6;
    sink_idle_pct = 84;
    goal = fed_items + 300;
    while (fed_items < goal) random_session();

    // ---- random, sender mostly idle, receiver mostly ready ----
    src_idle_pct  = 84;
    sink_idle_pct = 6;
    goal = fed_items + 300;
    while (fed_items < goal) random_session();

    // ---- no idling ----
    src_idle_pct  = 0;
    sink_idle_pct = 0;

    // Long receiver hold-off while reads keep coming: the output register
    // fills, the block takes one more request and then has to stall its input.
    @(posedge clk);
    sink_hold = 400;
    @(negedge clk);
    for (i = 0; i < 16; i++) offer(sisu_pkg::REQ_READ, -1, $urandom_range(0, 255));

    // Full-size set: 250 stored entries spaced at least 2 apart, six new
    // ones on top reach positions 250..255 and size 256. Then a full set
    // rejects appends and any new merge element overflows.
    offer(sisu_pkg::REQ_CLEAR, -1, sisu_pkg::MAX_CAPACITY);
    for (i = 0; i < sisu_pkg::MAX_CAPACITY - 6; i++)
      offer(sisu_pkg::REQ_APPEND, i * 260 + $urandom_range(0, 258), -1);
    offer(sisu_pkg::REQ_BEGIN, -1, 0);
    for (i = 0; i < 6; i++) offer(sisu_pkg::REQ_ELEM, 65530 + i, -1);
    offer(sisu_pkg::REQ_END, -1, -1);
    offer(sisu_pkg::REQ_APPEND, 65535, -1);
    offer(sisu_pkg::REQ_READ, -1, 255);
    offer(sisu_pkg::REQ_BEGIN, -1, 0);
    offer(sisu_pkg::REQ_ELEM, int'(sb.stored_rows[0]) + 1, -1);
    offer(sisu_pkg::REQ_END, -1, -1);

    goal = fed_items + 60;
    while (fed_items < goal) random_session();

    // ---- drain ----
    req_ch.valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sisu_pkg.sv
src/sisu_req_if.sv
src/sisu_rsp_if.sv
src/sisu_ctrl.sv
src/sisu_dp.sv
src/sorted_index_set_union.sv
verif/tb.sv
